@@ hdl/ssd_pkg.sv @@
// Shared types, command bytes and segment font for the serial seven-segment driver.
// No dependencies.
package ssd_pkg;

    localparam int VALUE_W      = 16;
    localparam int STEP_TICKS_W = 16;
    localparam int BRIGHT_W     = 3;
    localparam int CFG_INDEX_W  = 1;
    localparam int CFG_DATA_W   = 16;
    localparam int NUM_W        = 10;

    typedef logic [7:0] seg_byte_t;
    typedef logic [3:0] digit_t;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] CFG_STEP_TICKS = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BRIGHTNESS = 1'b1;

    localparam logic [STEP_TICKS_W-1:0] STEP_TICKS_RESET = 16'd1;
    localparam logic [BRIGHT_W-1:0]     BRIGHT_RESET     = 3'd4;

    localparam logic [VALUE_W-1:0] VALUE_LIMIT = 16'd1000;
    localparam logic [NUM_W-1:0]   VALUE_SAT   = 10'd999;

    localparam seg_byte_t CMD_AUTO_INC = 8'h40;
    localparam seg_byte_t CMD_ADDR_SET = 8'hC0;
    localparam seg_byte_t CMD_DISP_ON  = 8'h88;

    function automatic seg_byte_t seg_font(input digit_t d);
        seg_byte_t s;
        case (d)
            4'd0:    s = 8'h3F;
            4'd1:    s = 8'h06;
            4'd2:    s = 8'h5B;
            4'd3:    s = 8'h4F;
            4'd4:    s = 8'h66;
            4'd5:    s = 8'h6D;
            4'd6:    s = 8'h7D;
            4'd7:    s = 8'h07;
            4'd8:    s = 8'h7F;
            4'd9:    s = 8'h6F;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

endpackage

@@ hdl/ssd_item_if.sv @@
// Input item channel: opcode and value with valid/ready.
// Depends on ssd_pkg.
interface ssd_item_if;
    logic                         valid;
    logic                         ready;
    logic                         opcode;
    logic [ssd_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);
endinterface

@@ hdl/ssd_result_if.sv @@
// Result item channel: pin levels and status with valid/ready.
// No dependencies.
interface ssd_result_if;
    logic valid;
    logic ready;
    logic data_line;
    logic clock_line;
    logic busy_res;
    logic accepted;

    modport source (output valid, output data_line, output clock_line, output busy_res,
                    output accepted, input ready);
    modport sink   (input valid, input data_line, input clock_line, input busy_res,
                    input accepted, output ready);
endinterface

@@ hdl/ssd_cfg_if.sv @@
// Configuration write channel: register index and data with valid/ready.
// Depends on ssd_pkg.
interface ssd_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [ssd_pkg::CFG_INDEX_W-1:0]  index;
    logic [ssd_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hdl/seven_segment_serial_display_driver_core.sv @@
// Serial seven-segment display driver: sequencer for the two-wire LED controller pins.
// Depends on ssd_pkg, ssd_item_if, ssd_result_if, ssd_cfg_if.
//
// One item is taken per clock cycle while the output register is empty or being read; each
// gives one result, held in that output register until taken. A load (when idle) latches
// the number, saturated to 999; two pipeline registers split it into digits and segment bytes,
// ready long before the first data byte goes out. Tick items advance a hold counter; every
// step_ticks ticks the sequencer applies one pin change, 159 changes over three frames
// (0x40; 0xC0 and three digit bytes; 0x88 | brightness), LSB first. A load while busy is
// reported with accepted = 0 and changes nothing. Configuration writes are taken every cycle.
module seven_segment_serial_display_driver_core (
    input  logic                clk,
    input  logic                rst_n,
    ssd_item_if.sink            items,
    ssd_result_if.source        results,
    ssd_cfg_if.sink             cfg
);

    localparam logic [1:0] SEQ_START = 2'd0;
    localparam logic [1:0] SEQ_BITS  = 2'd1;
    localparam logic [1:0] SEQ_STOP  = 2'd2;

    localparam logic [1:0] FRAME_MODE = 2'd0;
    localparam logic [1:0] FRAME_DATA = 2'd1;
    localparam logic [1:0] FRAME_CTRL = 2'd2;

    localparam logic [1:0] PH_CLK_LOW  = 2'd0;
    localparam logic [1:0] PH_DATA     = 2'd1;
    localparam logic [1:0] PH_CLK_HIGH = 2'd2;

    localparam logic [1:0] STOP_CLK_LOW  = 2'd0;
    localparam logic [1:0] STOP_DATA_LOW = 2'd1;
    localparam logic [1:0] STOP_CLK_HIGH = 2'd2;
    localparam logic [1:0] STOP_DATA_HI  = 2'd3;

    localparam logic [1:0] DATA_LAST_BYTE = 2'd3;
    localparam logic [1:0] ONE_LAST_BYTE  = 2'd0;

    logic [ssd_pkg::STEP_TICKS_W-1:0] step_ticks_reg;
    logic [ssd_pkg::BRIGHT_W-1:0]     bright_reg;

    logic [ssd_pkg::STEP_TICKS_W-1:0] hold_reg, hold_next;
    logic [1:0]                       seq_reg, seq_next;
    logic [1:0]                       frame_reg, frame_next;
    logic [1:0]                       byte_reg, byte_next;
    logic [2:0]                       bit_reg, bit_next;
    logic [1:0]                       phase_reg, phase_next;
    logic                             data_reg, data_next;
    logic                             clock_reg, clock_next;
    logic                             sending_reg, sending_next;
    logic                             accepted_next;
    logic                             out_valid_reg;
    logic                             out_data_reg, out_clock_reg, out_busy_reg, out_acc_reg;

    logic [ssd_pkg::NUM_W-1:0]        num_reg, num_next;
    ssd_pkg::digit_t                  hund_reg;
    logic [6:0]                       rem_reg;
    ssd_pkg::seg_byte_t               seg_reg [3];

    ssd_pkg::digit_t                  hund_next, tens, ones;
    logic [6:0]                       rem_next;
    ssd_pkg::seg_byte_t               tx_byte;
    logic [1:0]                       last_byte;
    logic [ssd_pkg::STEP_TICKS_W:0]   waited;
    logic                             item_fire;

    assign item_fire   = items.valid & items.ready;
    assign items.ready = ~out_valid_reg | results.ready;
    assign cfg.ready   = 1'b1;

    assign results.valid      = out_valid_reg;
    assign results.data_line  = out_data_reg;
    assign results.clock_line = out_clock_reg;
    assign results.busy_res   = out_busy_reg;
    assign results.accepted   = out_acc_reg;

    // Digit split of the latched number
    always_comb
    begin
        hund_next = '0;
        for (int k = 1; k <= 9; k++)
        begin
            if (num_reg >= 10'(k * 100))
            begin
                hund_next = 4'(k);
            end
        end
        rem_next = 7'(num_reg - 10'(hund_next * 10'd100));
        tens = '0;
        for (int k = 1; k <= 9; k++)
        begin
            if (rem_reg >= 7'(k * 10))
            begin
                tens = 4'(k);
            end
        end
        ones = 4'(rem_reg - 7'(tens * 7'd10));
    end

    always_comb
    begin
        case (frame_reg)
            FRAME_MODE:
            begin
                tx_byte   = ssd_pkg::CMD_AUTO_INC;
                last_byte = ONE_LAST_BYTE;
            end
            FRAME_DATA:
            begin
                last_byte = DATA_LAST_BYTE;
                case (byte_reg)
                    2'd0:    tx_byte = ssd_pkg::CMD_ADDR_SET;
                    2'd1:    tx_byte = seg_reg[0];
                    2'd2:    tx_byte = seg_reg[1];
                    default: tx_byte = seg_reg[2];
                endcase
            end
            default:
            begin
                tx_byte   = ssd_pkg::CMD_DISP_ON | {5'd0, bright_reg};
                last_byte = ONE_LAST_BYTE;
            end
        endcase
    end

    always_comb
    begin
        hold_next     = hold_reg;
        seq_next      = seq_reg;
        frame_next    = frame_reg;
        byte_next     = byte_reg;
        bit_next      = bit_reg;
        phase_next    = phase_reg;
        data_next     = data_reg;
        clock_next    = clock_reg;
        sending_next  = sending_reg;
        num_next      = num_reg;
        accepted_next = 1'b0;
        waited        = {1'b0, hold_reg} + 17'd1;

        if (item_fire)
        begin
            if (items.opcode == ssd_pkg::OP_LOAD)
            begin
                if (!sending_reg)
                begin
                    num_next      = (items.value >= ssd_pkg::VALUE_LIMIT) ? ssd_pkg::VALUE_SAT
                                                                         : items.value[9:0];
                    hold_next     = '0;
                    seq_next      = SEQ_START;
                    frame_next    = FRAME_MODE;
                    sending_next  = 1'b1;
                    accepted_next = 1'b1;
                end
            end
            else if (sending_reg)
            begin
                if (waited >= {1'b0, step_ticks_reg})
                begin
                    hold_next = '0;
                    case (seq_reg)
                        SEQ_START:
                        begin
                            data_next  = 1'b0;
                            seq_next   = SEQ_BITS;
                            byte_next  = '0;
                            bit_next   = '0;
                            phase_next = PH_CLK_LOW;
                        end
                        SEQ_BITS:
                        begin
                            case (phase_reg)
                                PH_CLK_LOW:
                                begin
                                    clock_next = 1'b0;
                                    phase_next = PH_DATA;
                                end
                                PH_DATA:
                                begin
                                    data_next  = tx_byte[bit_reg];
                                    phase_next = PH_CLK_HIGH;
                                end
                                default:
                                begin
                                    clock_next = 1'b1;
                                    phase_next = PH_CLK_LOW;
                                    bit_next   = bit_reg + 3'd1;
                                    if (bit_reg == 3'd7)
                                    begin
                                        byte_next = byte_reg + 2'd1;
                                        if (byte_reg == last_byte)
                                        begin
                                            seq_next   = SEQ_STOP;
                                            phase_next = STOP_CLK_LOW;
                                        end
                                    end
                                end
                            endcase
                        end
                        default:
                        begin
                            phase_next = phase_reg + 2'd1;
                            case (phase_reg)
                                STOP_CLK_LOW:  clock_next = 1'b0;
                                STOP_DATA_LOW: data_next  = 1'b0;
                                STOP_CLK_HIGH: clock_next = 1'b1;
                                default:
                                begin
                                    data_next = 1'b1;
                                    if (frame_reg == FRAME_CTRL)
                                    begin
                                        sending_next = 1'b0;
                                    end
                                    else
                                    begin
                                        frame_next = frame_reg + 2'd1;
                                        seq_next   = SEQ_START;
                                    end
                                end
                            endcase
                        end
                    endcase
                end
                else
                begin
                    hold_next = waited[ssd_pkg::STEP_TICKS_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_ticks_reg <= ssd_pkg::STEP_TICKS_RESET;
            bright_reg     <= ssd_pkg::BRIGHT_RESET;
            hold_reg       <= '0;
            seq_reg        <= SEQ_START;
            frame_reg      <= FRAME_MODE;
            byte_reg       <= '0;
            bit_reg        <= '0;
            phase_reg      <= '0;
            data_reg       <= 1'b1;
            clock_reg      <= 1'b1;
            sending_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg.index)
                    ssd_pkg::CFG_STEP_TICKS: step_ticks_reg <= cfg.data;
                    ssd_pkg::CFG_BRIGHTNESS: bright_reg     <= cfg.data[ssd_pkg::BRIGHT_W-1:0];
                    default:                 bright_reg     <= bright_reg;
                endcase
            end
            hold_reg    <= hold_next;
            seq_reg     <= seq_next;
            frame_reg   <= frame_next;
            byte_reg    <= byte_next;
            bit_reg     <= bit_next;
            phase_reg   <= phase_next;
            data_reg    <= data_next;
            clock_reg   <= clock_next;
            sending_reg <= sending_next;
            if (item_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg    <= num_next;
        hund_reg   <= hund_next;
        rem_reg    <= rem_next;
        seg_reg[0] <= ssd_pkg::seg_font(hund_reg);
        seg_reg[1] <= ssd_pkg::seg_font(tens);
        seg_reg[2] <= ssd_pkg::seg_font(ones);
        if (item_fire)
        begin
            out_data_reg  <= data_next;
            out_clock_reg <= clock_next;
            out_busy_reg  <= sending_next;
            out_acc_reg   <= accepted_next;
        end
    end

endmodule

@@ sim/ssd_pin_checker.sv @@
// Pin-level checker for the serial seven-segment driver: predicts every result item
// from the accepted items and register writes and compares it field by field.
// Depends on ssd_pkg, ssd_item_if, ssd_result_if, ssd_cfg_if.
`timescale 1ns / 100ps

module ssd_pin_checker (
    input  logic    clk,
    input  logic    rst_n,
    ssd_item_if     items,
    ssd_result_if   results,
    ssd_cfg_if      cfg,
    output int      fail_count,
    output int      pending
);

    localparam int PIN_STEPS     = 159;
    localparam int FRAME_A_STEPS = 29;
    localparam int FRAME_B_STEPS = 101;

    typedef struct packed {
        logic data_line;
        logic clock_line;
        logic busy_res;
        logic accepted;
    } pin_levels_t;

    ssd_pkg::seg_byte_t                  glyph_buf [3];
    logic [7:0]                          step_no;
    logic [15:0]                         held_ticks;
    logic                                data_lvl;
    logic                                clock_lvl;
    logic                                sending_seq;
    logic [ssd_pkg::STEP_TICKS_W-1:0]    ticks_per_step;
    logic [ssd_pkg::BRIGHT_W-1:0]        bright;

    pin_levels_t                due_levels [$];
    pin_levels_t                seen_levels;
    pin_levels_t                want_levels;

    function automatic ssd_pkg::seg_byte_t glyph_of(input int digit);
        ssd_pkg::seg_byte_t g;
        case (digit)
            0:       g = 8'h3F;
            1:       g = 8'h06;
            2:       g = 8'h5B;
            3:       g = 8'h4F;
            4:       g = 8'h66;
            5:       g = 8'h6D;
            6:       g = 8'h7D;
            7:       g = 8'h07;
            8:       g = 8'h7F;
            default: g = 8'h6F;
        endcase
        return g;
    endfunction

    function automatic ssd_pkg::seg_byte_t frame_octet(input int frame, input int slot);
        if (frame == 0)
            return ssd_pkg::CMD_AUTO_INC;
        if (frame == 2)
            return ssd_pkg::CMD_DISP_ON | {5'b0, bright};
        if (slot == 0)
            return ssd_pkg::CMD_ADDR_SET;
        return glyph_buf[(slot - 1) % 3];
    endfunction

    task automatic apply_pin_step(input int k);
        int                 frame;
        int                 off;
        int                 nbytes;
        int                 j;
        ssd_pkg::seg_byte_t octet;
        if (k < FRAME_A_STEPS)
        begin
            frame = 0; off = k; nbytes = 1;
        end
        else if (k < FRAME_A_STEPS + FRAME_B_STEPS)
        begin
            frame = 1; off = k - FRAME_A_STEPS; nbytes = 4;
        end
        else
        begin
            frame = 2; off = k - FRAME_A_STEPS - FRAME_B_STEPS; nbytes = 1;
        end
        if (off == 0)
            data_lvl = 1'b0;
        else if (off <= 24 * nbytes)
        begin
            j = off - 1;
            case (j % 3)
                0:       clock_lvl = 1'b0;
                1:
                begin
                    octet    = frame_octet(frame, j / 24);
                    data_lvl = octet[(j % 24) / 3];
                end
                default: clock_lvl = 1'b1;
            endcase
        end
        else
        begin
            case (off - 1 - 24 * nbytes)
                0:       clock_lvl = 1'b0;
                1:       data_lvl  = 1'b0;
                2:       clock_lvl = 1'b1;
                default: data_lvl  = 1'b1;
            endcase
        end
    endtask

    task automatic advance_pins(input logic op, input logic [ssd_pkg::VALUE_W-1:0] num);
        int          shown;
        logic [16:0] waited;
        logic        taken;
        taken = 1'b0;
        if (op == ssd_pkg::OP_LOAD)
        begin
            if (!sending_seq)
            begin
                shown        = (num >= ssd_pkg::VALUE_LIMIT) ? int'(ssd_pkg::VALUE_SAT)
                                                             : int'(num);
                glyph_buf[0] = glyph_of(shown / 100);
                glyph_buf[1] = glyph_of((shown / 10) % 10);
                glyph_buf[2] = glyph_of(shown % 10);
                step_no      = 8'd0;
                held_ticks   = 16'd0;
                sending_seq  = 1'b1;
                taken        = 1'b1;
            end
        end
        else if (sending_seq)
        begin
            waited = {1'b0, held_ticks} + 17'd1;
            if (waited >= {1'b0, ticks_per_step})
            begin
                held_ticks = 16'd0;
                apply_pin_step(step_no);
                step_no = step_no + 8'd1;
                if (step_no >= PIN_STEPS)
                begin
                    step_no     = 8'd0;
                    sending_seq = 1'b0;
                end
            end
            else
                held_ticks = waited[15:0];
        end
        want_levels = '{data_lvl, clock_lvl, sending_seq, taken};
        due_levels.push_back(want_levels);
    endtask

    task automatic check_field(input string name, input logic want, input logic got);
        if (got !== want)
        begin
            fail_count++;
            $display("%0t: %s expected %0b actual %0b", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
                glyph_buf[i] = 8'h00;
            step_no        = 8'd0;
            held_ticks     = 16'd0;
            data_lvl       = 1'b1;
            clock_lvl      = 1'b1;
            sending_seq    = 1'b0;
            ticks_per_step = ssd_pkg::STEP_TICKS_RESET;
            bright         = ssd_pkg::BRIGHT_RESET;
            due_levels.delete();
            fail_count     = 0;
            pending       <= 0;
        end
        else
        begin
            if (results.valid && results.ready)
            begin
                seen_levels = '{results.data_line, results.clock_line,
                                results.busy_res, results.accepted};
                if (due_levels.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result with no item outstanding, expected none actual %b",
                             $time, seen_levels);
                end
                else
                begin
                    want_levels = due_levels.pop_front();
                    check_field("data_line", want_levels.data_line, seen_levels.data_line);
                    check_field("clock_line", want_levels.clock_line, seen_levels.clock_line);
                    check_field("busy_res", want_levels.busy_res, seen_levels.busy_res);
                    check_field("accepted", want_levels.accepted, seen_levels.accepted);
                end
            end
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == ssd_pkg::CFG_STEP_TICKS)
                    ticks_per_step = cfg.data[ssd_pkg::STEP_TICKS_W-1:0];
                else if (cfg.index == ssd_pkg::CFG_BRIGHTNESS)
                    bright = cfg.data[ssd_pkg::BRIGHT_W-1:0];
            end
            if (items.valid && items.ready)
                advance_pins(items.opcode, items.value);
            pending <= due_levels.size();
        end
    end

endmodule

@@ sim/seven_segment_serial_display_driver_core_tb.sv @@
// Top of the serial seven-segment driver test: clock, reset, item and register stimulus
// under several idle and stall mixes, and the verdict from ssd_pin_checker.
// Depends on ssd_pkg, the three channel interfaces, the driver core and ssd_pin_checker.
`timescale 1ns / 100ps

module seven_segment_serial_display_driver_core_tb;

    localparam int CLK_HALF       = 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SQUEEZE_CYCLES = 300;
    localparam int PHASE_ITEMS    = 80;

    logic            clk = 1'b0;
    logic            rst_n;
    int              fail_count;
    int              pending;
    int              gap_pct;
    int              stall_pct;
    int              offered;
    int              idle_cycles;
    logic            squeeze_req;

    int gap_by_phase   [4] = '{0, 87, 0, 28};
    int stall_by_phase [4] = '{0, 0, 87, 28};

    ssd_item_if   items ();
    ssd_result_if results ();
    ssd_cfg_if    cfg ();

    seven_segment_serial_display_driver_core i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items),
        .results (results),
        .cfg     (cfg)
    );

    ssd_pin_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .items      (items),
        .results    (results),
        .cfg        (cfg),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #CLK_HALF clk = ~clk;

    task automatic send_item(input logic op, input logic [ssd_pkg::VALUE_W-1:0] num);
        if ($urandom_range(99) < gap_pct)
        begin
            items.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < gap_pct);
        end
        items.valid  <= 1'b1;
        items.opcode <= op;
        items.value  <= num;
        do @(posedge clk); while (!items.ready);
        offered++;
    endtask

    task automatic send_ticks(input int count);
        repeat (count)
            send_item(ssd_pkg::OP_TICK, 16'($urandom));
    endtask

    task automatic set_config(input logic [15:0] steps,
                              input logic [ssd_pkg::BRIGHT_W-1:0] level);
        items.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        cfg.valid <= 1'b1;
        cfg.index <= ssd_pkg::CFG_STEP_TICKS;
        cfg.data  <= steps;
        do @(posedge clk); while (!cfg.ready);
        cfg.index <= ssd_pkg::CFG_BRIGHTNESS;
        cfg.data  <= {{(ssd_pkg::CFG_DATA_W-ssd_pkg::BRIGHT_W){1'b0}}, level};
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
    endtask

    function automatic logic [ssd_pkg::VALUE_W-1:0] pick_value();
        logic [ssd_pkg::VALUE_W-1:0] v;
        case ($urandom_range(6))
            0:       v = 16'd0;
            1:       v = 16'd999;
            2:       v = ssd_pkg::VALUE_LIMIT;
            3:       v = 16'hFFFF;
            4:       v = 16'($urandom_range(998, 1));
            5:       v = 16'($urandom_range(65534, 1001));
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    function automatic logic [15:0] pick_steps();
        logic [15:0] s;
        case ($urandom_range(3))
            0:       s = 16'd0;
            3:       s = 16'd2;
            default: s = 16'd1;
        endcase
        return s;
    endfunction

    // Loads inside the tick stream mostly land while busy.
    task automatic run_sequence(input logic [ssd_pkg::VALUE_W-1:0] num, input int tick_total);
        send_item(ssd_pkg::OP_LOAD, num);
        for (int n = 0; n < tick_total; n++)
        begin
            if ($urandom_range(99) < 4)
                send_item(ssd_pkg::OP_LOAD, pick_value());
            send_item(ssd_pkg::OP_TICK, 16'($urandom));
        end
    endtask

    initial
    begin : receiver
        logic squeezed;
        squeezed       = 1'b0;
        results.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (squeeze_req && !squeezed)
            begin
                squeezed       = 1'b1;
                results.ready <= 1'b0;
                repeat (SQUEEZE_CYCLES) @(posedge clk);
            end
            else
                results.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (items.valid && items.ready) || (results.valid && results.ready)
            || (cfg.valid && cfg.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("seven_segment_serial_display_driver_core test failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        int base;
        int r;
        rst_n        <= 1'b0;
        items.valid  <= 1'b0;
        items.opcode <= ssd_pkg::OP_TICK;
        items.value  <= '0;
        cfg.valid    <= 1'b0;
        cfg.index    <= ssd_pkg::CFG_STEP_TICKS;
        cfg.data     <= '0;
        squeeze_req  <= 1'b0;
        gap_pct       = 0;
        stall_pct     = 0;
        offered       = 0;
        idle_cycles   = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // zero step length acts as one tick per step
        set_config(16'd0, 3'd0);
        send_item(ssd_pkg::OP_TICK, 16'hFFFF);
        send_item(ssd_pkg::OP_TICK, 16'h0000);
        send_item(ssd_pkg::OP_LOAD, ssd_pkg::VALUE_LIMIT);
        send_item(ssd_pkg::OP_LOAD, 16'd0);
        send_ticks(158);
        send_item(ssd_pkg::OP_LOAD, 16'd999);
        send_ticks(2);
        squeeze_req <= 1'b1;
        run_sequence(16'hFFFF, 159);

        // long step length, then lower it and the brightness mid-sequence
        set_config(16'hFFFF, 3'd7);
        send_item(ssd_pkg::OP_LOAD, 16'd123);
        send_ticks(10);
        set_config(16'd2, 3'd3);
        send_ticks(60);
        set_config(16'd1, 3'd0);
        send_ticks(131);

        for (int p = 0; p < 4; p++)
        begin
            set_config(pick_steps(), 3'($urandom_range(7)));
            gap_pct   = gap_by_phase[p];
            stall_pct = stall_by_phase[p];
            base      = offered;
            while (offered - base < PHASE_ITEMS)
            begin
                r = $urandom_range(99);
                if (r < 80)
                    run_sequence(pick_value(),
                                 $urandom_range(PHASE_ITEMS - (offered - base), 1));
                else if (r < 93)
                    send_ticks($urandom_range(5, 1));
                else
                    set_config(pick_steps(), 3'($urandom_range(7)));
            end
        end

        items.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
        if (fail_count == 0)
            $display("seven_segment_serial_display_driver_core test passed");
        else
            $display("seven_segment_serial_display_driver_core test failed");
        $finish;
    end

endmodule
